/* design/bpa_pkg.sv */
// Shared types and constants for the bitmap page allocator.
// Used by bpa_ctrl, bpa_datapath and bitmap_page_allocator.
`default_nettype none

package bpa_pkg;

    localparam int MAX_PAGES_DEF     = 4096;
    localparam int MAP_WORD_BITS_DEF = 64;
    localparam int PAGE_W            = 12;
    localparam int COUNT_W           = 13;
    localparam int PG_W              = 14;
    localparam int CHUNK_BITS        = 8;

    typedef enum logic [1:0] {
        MODE_ALLOC     = 2'd0,
        MODE_FREE      = 2'd1,
        MODE_MARK_USED = 2'd2,
        MODE_MARK_FREE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_MEMORY   = 2'd1,
        ST_INVALID     = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SC_RD,
        S_SC_CHK,
        S_HIT,
        S_MISS,
        S_WR_RD,
        S_WR_WB,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_STEP,
        OP_LOAD,
        OP_SCAN_HINT,
        OP_SCAN_FREE,
        OP_SCAN_WRAP,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_WR_RANGE,
        OP_WR_ALLOC,
        OP_WR_FREE_PART,
        OP_WR_FREE_ALL,
        OP_WR_RD,
        OP_WR_WB
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        logic    set_status;
        t_status status;
        logic    load_out;
    } t_dp_cmd;

    typedef struct packed {
        t_mode mode;
        logic  init_last;
        logic  cnt_zero;
        logic  free_bad;
        logic  range_bad;
        logic  cur_past;
        logic  chk_hit;
        logic  chk_miss;
        logic  word_end;
        logic  wr_last;
        logic  pass2;
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/bpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpa_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/bpa_ctrl.sv */
// Sequencer for the bitmap page allocator: clearing pass, scan, mark, result.
// Depends on bpa_pkg.
`default_nettype none

module bpa_ctrl
    import bpa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_s_tvalid,
    output logic          o_s_tready,
    input  wire logic     i_m_tready,
    output logic          o_m_tvalid,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_m_tvalid, n_m_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        o_cmd      = '{op: OP_NONE, set_status: 1'b0, status: ST_OK, load_out: 1'b0};
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = OP_INIT_STEP;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                unique case (i_stat.mode)
                    MODE_ALLOC: begin
                        if (i_stat.cnt_zero) begin
                            o_cmd.status = ST_INVALID;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.op = OP_SCAN_HINT;
                            n_state  = S_SC_RD;
                        end
                    end
                    MODE_FREE: begin
                        priority if (i_stat.free_bad) begin
                            o_cmd.status = ST_INVALID;
                            n_state      = S_DONE;
                        end else if (i_stat.cnt_zero) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.op = OP_SCAN_FREE;
                            n_state  = S_SC_RD;
                        end
                    end
                    default: begin
                        if (i_stat.range_bad) begin
                            o_cmd.status = ST_INVALID;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.op = OP_WR_RANGE;
                            n_state  = S_WR_RD;
                        end
                    end
                endcase
            end
            S_SC_RD: begin
                if (i_stat.cur_past) begin
                    n_state = S_MISS;
                end else begin
                    o_cmd.op = OP_SCAN_RD;
                    n_state  = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                o_cmd.op = OP_SCAN_CHK;
                priority if (i_stat.chk_hit) begin
                    n_state = S_HIT;
                end else if (i_stat.chk_miss) begin
                    n_state = S_MISS;
                end else if (i_stat.word_end) begin
                    n_state = S_SC_RD;
                end
            end
            S_HIT: begin
                o_cmd.set_status = 1'b1;
                n_state          = S_WR_RD;
                if (i_stat.mode == MODE_ALLOC) begin
                    o_cmd.op     = OP_WR_ALLOC;
                    o_cmd.status = ST_OK;
                end else begin
                    o_cmd.op     = OP_WR_FREE_PART;
                    o_cmd.status = ST_DOUBLE_FREE;
                end
            end
            S_MISS: begin
                priority if (i_stat.mode == MODE_ALLOC && !i_stat.pass2) begin
                    o_cmd.op = OP_SCAN_WRAP;
                    n_state  = S_SC_RD;
                end else if (i_stat.mode == MODE_ALLOC) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = ST_NO_MEMORY;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.op = OP_WR_FREE_ALL;
                    n_state  = S_WR_RD;
                end
            end
            S_WR_RD: begin
                if (i_stat.cur_past) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_WR_RD;
                    n_state  = S_WR_WB;
                end
            end
            S_WR_WB: begin
                o_cmd.op = OP_WR_WB;
                n_state  = i_stat.wr_last ? S_DONE : S_WR_RD;
            end
            S_DONE: begin
                if (!r_m_tvalid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_m_tvalid     = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;

endmodule

`default_nettype wire

/* design/bpa_datapath.sv */
// Datapath of the bitmap page allocator: page map RAM, scan and mark logic,
// bounds, next-fit hint and result registers. Depends on bpa_pkg and bpa_ram.
`default_nettype none

module bpa_datapath
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES     = MAX_PAGES_DEF,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat,
    input  wire logic [1:0]         i_mode,
    input  wire logic [PAGE_W-1:0]  i_first_page,
    input  wire logic [COUNT_W-1:0] i_end_page,
    input  wire logic [COUNT_W-1:0] i_page_count,
    input  wire logic [COUNT_W-1:0] i_total_pages,
    output t_status                 o_status,
    output logic      [PAGE_W-1:0]  o_start_page
);

    localparam int WORDS = MAX_PAGES / MAP_WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(MAP_WORD_BITS);
    localparam int CAP   = (MAX_PAGES > (1 << COUNT_W) - 1) ? (1 << COUNT_W) - 1 : MAX_PAGES;
    localparam logic [PG_W-1:0] TOTAL_CAP  = PG_W'(CAP);
    localparam logic [PG_W-1:0] WORD_STEP  = PG_W'(MAP_WORD_BITS);
    localparam logic [PG_W-1:0] CHUNK_STEP = PG_W'(CHUNK_BITS);
    localparam logic [BW-1:0]   LAST_CHUNK = BW'(MAP_WORD_BITS - CHUNK_BITS);
    localparam logic [AW-1:0]   LAST_WORD  = AW'(WORDS - 1);

    function automatic logic [AW-1:0] word_of(input logic [PG_W-1:0] page);
        logic [PG_W+AW-1:0] ext;
        ext = {{AW{1'b0}}, page};
        return ext[BW +: AW];
    endfunction

    t_mode               r_mode;
    logic [PG_W-1:0]     r_first, r_end, r_hint, r_lo, r_hi, r_cur, r_found;
    logic [COUNT_W-1:0]  r_cnt, r_need, r_run;
    logic                r_val, r_pass2;
    logic [AW-1:0]       r_init_addr;
    t_status             r_status, r_out_status;
    logic [PAGE_W-1:0]   r_out_start;

    logic [PG_W-1:0]          total_eff, cnt_ext, free_hi, wrap_sum, wrap_hi, alloc_hi;
    logic [PG_W-1:0]          chunk_base, chunk_next, hit_page, found_nxt, page_i;
    logic [PG_W-1:0]          wbase, wnext, wpage;
    logic [BW-1:0]            sh;
    logic [CHUNK_BITS-1:0]    chunk_bits;
    logic [COUNT_W-1:0]       run_v;
    logic                     hit;
    logic [MAP_WORD_BITS-1:0] rdata, mask, wdata_mod;
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata;

    assign total_eff = (PG_W'(i_total_pages) > TOTAL_CAP) ? TOTAL_CAP : PG_W'(i_total_pages);
    assign cnt_ext   = PG_W'(r_cnt);
    assign free_hi   = r_first + cnt_ext;
    assign wrap_sum  = r_hint + cnt_ext;
    assign wrap_hi   = (wrap_sum > total_eff) ? total_eff : wrap_sum;
    assign alloc_hi  = r_found + cnt_ext;

    assign sh         = r_cur[BW-1:0] & ~BW'(CHUNK_BITS - 1);
    assign chunk_bits = CHUNK_BITS'(rdata >> sh);
    assign chunk_base = r_cur & ~PG_W'(CHUNK_BITS - 1);
    assign chunk_next = chunk_base + CHUNK_STEP;

    always_comb begin
        run_v    = r_run;
        hit      = 1'b0;
        hit_page = '0;
        page_i   = '0;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            page_i = chunk_base + PG_W'(i);
            if (!hit && page_i >= r_lo && page_i < r_hi) begin
                if (chunk_bits[i]) begin
                    run_v = '0;
                end else begin
                    run_v = run_v + COUNT_W'(1);
                    if (run_v == r_need) begin
                        hit      = 1'b1;
                        hit_page = page_i;
                    end
                end
            end
        end
    end

    assign found_nxt = hit_page + PG_W'(1) - PG_W'(r_need);

    assign wbase = r_cur & ~PG_W'(MAP_WORD_BITS - 1);
    assign wnext = wbase + WORD_STEP;

    always_comb begin
        mask  = '0;
        wpage = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++) begin
            wpage   = wbase + PG_W'(i);
            mask[i] = (wpage >= r_lo) && (wpage < r_hi);
        end
    end

    assign wdata_mod = r_val ? (rdata | mask) : (rdata & ~mask);

    assign ram_we    = (i_cmd.op == OP_INIT_STEP) || (i_cmd.op == OP_WR_WB);
    assign ram_waddr = (i_cmd.op == OP_INIT_STEP) ? r_init_addr : word_of(r_cur);
    assign ram_wdata = (i_cmd.op == OP_INIT_STEP) ? '1 : wdata_mod;
    assign ram_re    = (i_cmd.op == OP_SCAN_RD) || (i_cmd.op == OP_WR_RD);
    assign ram_raddr = word_of(r_cur);

    bpa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint      <= '0;
            r_init_addr <= '0;
        end else begin
            if (i_cmd.op == OP_INIT_STEP) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            if (i_cmd.op == OP_WR_ALLOC) begin
                r_hint <= alloc_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_mode  <= t_mode'(i_mode);
                r_first <= PG_W'(i_first_page);
                r_end   <= PG_W'(i_end_page);
                r_cnt   <= i_page_count;
            end
            OP_SCAN_HINT: begin
                r_lo    <= r_hint;
                r_hi    <= total_eff;
                r_cur   <= r_hint;
                r_need  <= r_cnt;
                r_run   <= '0;
                r_pass2 <= 1'b0;
            end
            OP_SCAN_FREE: begin
                r_lo    <= r_first;
                r_hi    <= free_hi;
                r_cur   <= r_first;
                r_need  <= COUNT_W'(1);
                r_run   <= '0;
                r_pass2 <= 1'b0;
            end
            OP_SCAN_WRAP: begin
                r_lo    <= '0;
                r_hi    <= wrap_hi;
                r_cur   <= '0;
                r_run   <= '0;
                r_pass2 <= 1'b1;
            end
            OP_SCAN_CHK: begin
                r_run <= run_v;
                r_cur <= chunk_next;
                if (hit) begin
                    r_found <= found_nxt;
                end
            end
            OP_WR_RANGE: begin
                r_lo  <= r_first;
                r_hi  <= r_end;
                r_cur <= r_first;
                r_val <= (r_mode == MODE_MARK_USED);
            end
            OP_WR_ALLOC: begin
                r_lo  <= r_found;
                r_hi  <= alloc_hi;
                r_cur <= r_found;
                r_val <= 1'b1;
            end
            OP_WR_FREE_PART: begin
                r_lo  <= r_first;
                r_hi  <= r_found;
                r_cur <= r_first;
                r_val <= 1'b0;
            end
            OP_WR_FREE_ALL: begin
                r_lo  <= r_first;
                r_hi  <= free_hi;
                r_cur <= r_first;
                r_val <= 1'b0;
            end
            OP_WR_WB: begin
                r_cur <= wnext;
            end
            default: begin
            end
        endcase
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_start  <= (r_status == ST_OK && r_mode == MODE_ALLOC) ?
                            r_found[PAGE_W-1:0] : '0;
        end
    end

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.init_last = (r_init_addr == LAST_WORD);
        o_stat.cnt_zero  = (r_cnt == '0);
        o_stat.free_bad  = (free_hi > total_eff);
        o_stat.range_bad = (r_end > total_eff) || (r_first >= r_end);
        o_stat.cur_past  = (r_cur >= r_hi);
        o_stat.chk_hit   = hit;
        o_stat.chk_miss  = !hit && (chunk_next >= r_hi);
        o_stat.word_end  = (sh == LAST_CHUNK);
        o_stat.wr_last   = (wnext >= r_hi);
        o_stat.pass2     = r_pass2;
    end

    assign o_status     = r_out_status;
    assign o_start_page = r_out_start;

endmodule

`default_nettype wire

/* design/bitmap_page_allocator.sv */
// Top level of the bitmap page allocator: stream ports, APB register, sequencer
// and datapath. Depends on bpa_pkg, bpa_ctrl, bpa_datapath and bpa_ram.
//
//   Channel   Direction  Handshake                        Payload
//   s_*       in         s_tvalid / s_tready              mode, first, end, count
//   m_*       out        m_tvalid / m_tready              status, start page
//   apb       in         psel & penable & pwrite, pready  total_pages at 0x0
//
// Each transaction is handled alone. Allocate reads one map word and then
// checks 8 pages a cycle, word by word, over at most two passes. Marking
// reads and writes back each word touched. Every transaction also passes
// through decode and result states. After reset a clearing pass over all
// MAX_PAGES/MAP_WORD_BITS map words (64 at the defaults) sets every page
// used; s_tready stays low until it is done.
// A stalled result holds in the output register while the next item is taken.
`default_nettype none

module bitmap_page_allocator
    import bpa_pkg::*;
#(
    parameter int MAX_PAGES     = MAX_PAGES_DEF,
    parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // first_page[11:0], end_page[24:12], page_count[37:25]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // start_page[11:0]
    output logic      [1:0]  m_tuser,   // status[1:0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam logic REG_TOTAL_PAGES = 1'b0;
    localparam logic [COUNT_W-1:0] TOTAL_RESET = COUNT_W'(4096);

    logic [COUNT_W-1:0] r_total_pages;
    t_dp_cmd            cmd;
    t_dp_stat           stat;
    t_status            out_status;
    logic [PAGE_W-1:0]  out_start;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TOTAL_PAGES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_pages <= TOTAL_RESET;
        end else if (cfg_wr) begin
            r_total_pages <= pwdata[COUNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOTAL_PAGES) ? {{(32 - COUNT_W){1'b0}}, r_total_pages} : '0;

    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_m_tready (m_tready),
        .o_m_tvalid (m_tvalid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bpa_datapath #(
        .MAX_PAGES     (MAX_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (s_tuser),
        .i_first_page  (s_tdata[11:0]),
        .i_end_page    (s_tdata[24:12]),
        .i_page_count  (s_tdata[37:25]),
        .i_total_pages (r_total_pages),
        .o_status      (out_status),
        .o_start_page  (out_start)
    );

    assign m_tdata = {4'b0000, out_start};
    assign m_tuser = out_status;

endmodule

`default_nettype wire
